// File: hw/rtl/nnq_pkg.sv
// ----------------------------------------------------------------------------
// nnq_pkg
// Shared constants, types and helper functions of the nearest note quantizer.
// ----------------------------------------------------------------------------
package nnq_pkg;

    localparam int DEF_NUM_NOTES  = 112;
    localparam int DEF_FREQ_WIDTH = 24;

    localparam int A4_W    = 19;
    localparam int RATIO_W = 31;
    localparam int PROD_W  = A4_W + RATIO_W;
    localparam int IDX_W   = 7;
    localparam int PC_W    = 4;
    localparam int OCT_W   = 4;

    localparam logic [A4_W-1:0] A4_RESET = 19'd450560;

    // The entry of octave o is the product shifted right by 34 - o with rounding,
    // done as a shift by 33 - o, an increment and a shift by one.
    localparam logic [5:0] ROUND_SHIFT_BASE = 6'd33;

    localparam logic [PC_W-1:0] LAST_PC = 4'd11;

    typedef struct packed {
        logic build_init;
        logic build_mul;
        logic build_wr;
        logic srch_start;
        logic srch_step;
        logic fetch_hi;
        logic fetch_lo;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic build_last;
        logic srch_done;
    } t_dp_sts;

    // 2^((p-9)/12) scaled by 2^30, rounded.
    function automatic logic [RATIO_W-1:0] ratio(input logic [PC_W-1:0] pc);
        logic [RATIO_W-1:0] r;
        case (pc)
            4'd0:    r = 31'd638450708;
            4'd1:    r = 31'd676414963;
            4'd2:    r = 31'd716636690;
            4'd3:    r = 31'd759250125;
            4'd4:    r = 31'd804397487;
            4'd5:    r = 31'd852229450;
            4'd6:    r = 31'd902905651;
            4'd7:    r = 31'd956595215;
            4'd8:    r = 31'd1013477326;
            4'd9:    r = 31'd1073741824;
            4'd10:   r = 31'd1137589835;
            4'd11:   r = 31'd1205234447;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Division by 12 as a multiply by 43/512, exact for all 7-bit indexes.
    function automatic logic [OCT_W-1:0] idx_octave(input logic [IDX_W-1:0] idx);
        logic [12:0] prod;
        prod = 13'(idx) * 13'd43;
        return OCT_W'(prod >> 9);
    endfunction

    function automatic logic [PC_W-1:0] idx_pitch_class(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] base;
        base = IDX_W'(idx_octave(idx)) * IDX_W'(12);
        return PC_W'(idx - base);
    endfunction

endpackage

// File: hw/rtl/nnq_ram.sv
// ----------------------------------------------------------------------------
// nnq_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module nnq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 112
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/nnq_ctrl.sv
// ----------------------------------------------------------------------------
// nnq_ctrl
// Sequencer of the quantizer: table rebuild, binary search, neighbor fetch
// and the output register handshake.
// ----------------------------------------------------------------------------
module nnq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  nnq_pkg::t_dp_sts i_sts,
    output nnq_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_INIT = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_WR   = 8'b0000_0100,
        S_IDLE = 8'b0000_1000,
        S_SRCH = 8'b0001_0000,
        S_FHI  = 8'b0010_0000,
        S_FLO  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_load;

    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: n_state = S_MUL;
            S_MUL:  n_state = S_WR;
            S_WR:   n_state = i_sts.build_last ? S_IDLE : S_MUL;
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: n_state = i_sts.srch_done ? S_FHI : S_SRCH;
            S_FHI:  n_state = S_FLO;
            S_FLO:  n_state = S_DONE;
            S_DONE: n_state = w_load ? S_IDLE : S_DONE;
            default: n_state = S_INIT;
        endcase
        // A register write restarts the table rebuild.
        if (i_cfg_we) begin
            n_state = S_INIT;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.build_init = (r_state == S_INIT);
        o_cmd.build_mul  = (r_state == S_MUL);
        o_cmd.build_wr   = (r_state == S_WR);
        o_cmd.srch_start = (r_state == S_IDLE) && i_in_valid;
        o_cmd.srch_step  = (r_state == S_SRCH);
        o_cmd.fetch_hi   = (r_state == S_FHI);
        o_cmd.fetch_lo   = (r_state == S_FLO);
        o_cmd.out_load   = w_load;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/nnq_datapath.sv
// ----------------------------------------------------------------------------
// nnq_datapath
// Note table builder, search registers, midpoint compare and result registers.
// ----------------------------------------------------------------------------
module nnq_datapath #(
    parameter int NUM_NOTES  = nnq_pkg::DEF_NUM_NOTES,
    parameter int FREQ_WIDTH = nnq_pkg::DEF_FREQ_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nnq_pkg::A4_W-1:0]    i_cfg_wdata,
    input  logic [FREQ_WIDTH-1:0]       i_freq,
    input  nnq_pkg::t_dp_cmd            i_cmd,
    output nnq_pkg::t_dp_sts            o_sts,
    output logic [nnq_pkg::IDX_W-1:0]   o_idx,
    output logic [nnq_pkg::PC_W-1:0]    o_pc,
    output logic [nnq_pkg::OCT_W-1:0]   o_oct,
    output logic [FREQ_WIDTH-1:0]       o_note_freq
);

    localparam int AW = $clog2(NUM_NOTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_NOTES - 1);
    localparam logic [AW-1:0] MID0      = AW'((NUM_NOTES - 1) / 2);

    // Configuration register.
    logic [nnq_pkg::A4_W-1:0] r_a4;

    // Table build.
    logic [AW-1:0]                r_bidx;
    logic [nnq_pkg::PC_W-1:0]     r_bpc;
    logic [nnq_pkg::OCT_W-1:0]    r_boct;
    logic [nnq_pkg::PROD_W-1:0]   r_prod;
    logic [5:0]                   w_shift;
    logic [nnq_pkg::PROD_W-1:0]   w_shifted;
    logic [nnq_pkg::PROD_W:0]     w_rounded;
    logic [FREQ_WIDTH-1:0]        w_entry;

    // Search.
    logic [FREQ_WIDTH-1:0] r_freq;
    logic [AW-1:0]         r_lo, r_hi, r_mid;
    logic [AW-1:0]         n_lo, n_hi, n_mid;
    logic [AW:0]           w_mid_sum;
    logic                  w_ge;
    logic [FREQ_WIDTH-1:0] r_hi_val;
    logic [FREQ_WIDTH:0]   w_pair_sum;
    logic [FREQ_WIDTH:0]   w_twice;
    logic                  w_take_lo;

    // Result.
    logic [AW-1:0]         r_res_idx;
    logic [FREQ_WIDTH-1:0] r_res_freq;
    logic [nnq_pkg::IDX_W-1:0]  r_out_idx;
    logic [nnq_pkg::PC_W-1:0]   r_out_pc;
    logic [nnq_pkg::OCT_W-1:0]  r_out_oct;
    logic [FREQ_WIDTH-1:0]      r_out_freq;
    logic [nnq_pkg::IDX_W-1:0]  w_res_idx_ext;

    // RAM ports.
    logic [AW-1:0]         w_raddr;
    logic [FREQ_WIDTH-1:0] w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a4 <= nnq_pkg::A4_RESET;
        end else if (i_cfg_we) begin
            r_a4 <= i_cfg_wdata;
        end
    end

    // Entry = (a4 * ratio + 2^(s-1)) >> s with s = 34 - octave, saturated.
    assign w_shift   = nnq_pkg::ROUND_SHIFT_BASE - 6'(r_boct);
    assign w_shifted = r_prod >> w_shift;
    assign w_rounded = ({1'b0, w_shifted} + (nnq_pkg::PROD_W+1)'(1)) >> 1;
    assign w_entry   = ((w_rounded >> FREQ_WIDTH) != '0) ? '1 : w_rounded[FREQ_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.build_init) begin
            r_bidx <= '0;
            r_bpc  <= '0;
            r_boct <= '0;
        end else if (i_cmd.build_wr) begin
            r_bidx <= r_bidx + AW'(1);
            if (r_bpc == nnq_pkg::LAST_PC) begin
                r_bpc  <= '0;
                r_boct <= r_boct + nnq_pkg::OCT_W'(1);
            end else begin
                r_bpc <= r_bpc + nnq_pkg::PC_W'(1);
            end
        end
        if (i_cmd.build_mul) begin
            r_prod <= nnq_pkg::PROD_W'(r_a4) * nnq_pkg::PROD_W'(nnq_pkg::ratio(r_bpc));
        end
    end

    // One step of the lower-bound search: find the first entry not below freq.
    assign w_ge      = (w_rdata >= r_freq);
    assign n_lo      = w_ge ? r_lo : AW'({1'b0, r_mid} + (AW+1)'(1));
    assign n_hi      = w_ge ? r_mid : r_hi;
    assign w_mid_sum = {1'b0, n_lo} + {1'b0, n_hi};
    assign n_mid     = w_mid_sum[AW:1];

    // The lower neighbor wins only when freq lies strictly below the midpoint.
    assign w_pair_sum = {1'b0, w_rdata} + {1'b0, r_hi_val};
    assign w_twice    = {r_freq, 1'b0};
    assign w_take_lo  = (r_lo != '0) && (w_twice < w_pair_sum);

    always_comb begin
        case (1'b1)
            i_cmd.srch_start: w_raddr = MID0;
            i_cmd.srch_step:  w_raddr = n_mid;
            i_cmd.fetch_hi:   w_raddr = (r_lo == '0) ? '0 : r_lo - AW'(1);
            default:          w_raddr = r_mid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_start) begin
            r_freq <= i_freq;
            r_lo   <= '0;
            r_hi   <= LAST_ADDR;
            r_mid  <= MID0;
        end else if (i_cmd.srch_step) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= n_mid;
        end
        if (i_cmd.fetch_hi) begin
            r_hi_val <= w_rdata;
        end
        if (i_cmd.fetch_lo) begin
            r_res_idx  <= w_take_lo ? r_lo - AW'(1) : r_lo;
            r_res_freq <= w_take_lo ? w_rdata : r_hi_val;
        end
    end

    assign w_res_idx_ext = nnq_pkg::IDX_W'(r_res_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_idx  <= w_res_idx_ext;
            r_out_pc   <= nnq_pkg::idx_pitch_class(w_res_idx_ext);
            r_out_oct  <= nnq_pkg::idx_octave(w_res_idx_ext);
            r_out_freq <= r_res_freq;
        end
    end

    nnq_ram #(
        .WIDTH (FREQ_WIDTH),
        .DEPTH (NUM_NOTES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.build_wr),
        .i_waddr (r_bidx),
        .i_wdata (w_entry),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_sts.build_last = (r_bidx == LAST_ADDR);
    assign o_sts.srch_done  = (n_lo == n_hi);

    assign o_idx       = r_out_idx;
    assign o_pc        = r_out_pc;
    assign o_oct       = r_out_oct;
    assign o_note_freq = r_out_freq;

endmodule

// File: hw/rtl/nearest_note_quantizer.sv
// ----------------------------------------------------------------------------
// nearest_note_quantizer
// Maps a measured frequency to the nearest equal-tempered note above C0.
// ----------------------------------------------------------------------------
// After reset, and after every write of the concert A4 register, the block
// rebuilds its note table (an init step, then one multiply step and one RAM
// write step per note) and accepts no request meanwhile; a register write
// must only be made while the block is idle. Each request runs a binary search
// that uses the single read port of the table RAM once per step, then fetches
// the two neighboring entries and loads the result. The next request can be
// accepted in the cycle after the result is loaded.
// One request is in flight at a time; a finished result waits in the output
// register while the next request is accepted and searched.
module nearest_note_quantizer #(
    parameter int NUM_NOTES  = nnq_pkg::DEF_NUM_NOTES,
    parameter int FREQ_WIDTH = nnq_pkg::DEF_FREQ_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [nnq_pkg::A4_W-1:0]                i_cfg_wdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // freq
    input  logic [((FREQ_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // semitone_index, pitch_class, octave, note_freq
    output logic [((FREQ_WIDTH+15+7)/8)*8-1:0]      m_axis_tdata
);

    localparam int OUT_FIELDS_W = nnq_pkg::IDX_W + nnq_pkg::PC_W + nnq_pkg::OCT_W + FREQ_WIDTH;
    localparam int OUT_TDATA_W  = ((FREQ_WIDTH + 15 + 7) / 8) * 8;

    nnq_pkg::t_dp_cmd w_cmd;
    nnq_pkg::t_dp_sts w_sts;

    logic [nnq_pkg::IDX_W-1:0] w_idx;
    logic [nnq_pkg::PC_W-1:0]  w_pc;
    logic [nnq_pkg::OCT_W-1:0] w_oct;
    logic [FREQ_WIDTH-1:0]     w_note_freq;
    logic [OUT_FIELDS_W-1:0]   w_fields;

    nnq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    nnq_datapath #(
        .NUM_NOTES  (NUM_NOTES),
        .FREQ_WIDTH (FREQ_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_freq      (s_axis_tdata[FREQ_WIDTH-1:0]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_idx       (w_idx),
        .o_pc        (w_pc),
        .o_oct       (w_oct),
        .o_note_freq (w_note_freq)
    );

    assign w_fields     = {w_note_freq, w_oct, w_pc, w_idx};
    assign m_axis_tdata = OUT_TDATA_W'(w_fields);

`ifndef SYNTH
    // The controller issues at most one datapath command per cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command at once");

    // No request is taken while the note table is being rebuilt.
    a_no_accept_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.build_init || w_cmd.build_mul || w_cmd.build_wr) |-> !s_axis_tready)
        else $error("request accepted during table rebuild");

    // A result appears only after the result registers were loaded.
    a_valid_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.out_load))
        else $error("output valid without a result load");

    // The lower neighbor fetch is not directly followed by a search start or a table write.
    a_load_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fetch_lo |=> !w_cmd.srch_start && !w_cmd.build_wr)
        else $error("sequencer left the result step early");
`endif

endmodule

// File: sim/nearest_note_quantizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_note_quantizer_tb
// Self-checking bench for the nearest note quantizer. It holds its own copy
// of the note table, rebuilt from every concert A4 value written, and checks
// each result against the note predicted for the frequency of that request.
// The run steps through several A4 settings, including both ends of the
// legal range and degenerate values, with random idling on both sides.
// ----------------------------------------------------------------------------
module nearest_note_quantizer_tb;

    localparam int NOTES          = nnq_pkg::DEF_NUM_NOTES;
    localparam int FW             = nnq_pkg::DEF_FREQ_WIDTH;
    localparam int A4_W           = nnq_pkg::A4_W;
    localparam int IDX_W          = nnq_pkg::IDX_W;
    localparam int PC_W           = nnq_pkg::PC_W;
    localparam int OCT_W          = nnq_pkg::OCT_W;
    localparam int S_W            = ((FW + 7) / 8) * 8;
    localparam int M_W            = ((FW + 15 + 7) / 8) * 8;
    localparam int PHASES         = 9;
    localparam int RANDOM_PER_PH  = 50;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [63:0] FREQ_MAX = (64'd1 << FW) - 1;

    // Semitone ratios 2^((p-9)/12) scaled by 2^30, pitch class 0 in the lowest bits.
    localparam logic [12*31-1:0] SEMITONE_RATIOS = {
        31'd1205234447, 31'd1137589835, 31'd1073741824, 31'd1013477326,
        31'd956595215,  31'd902905651,  31'd852229450,  31'd804397487,
        31'd759250125,  31'd716636690,  31'd676414963,  31'd638450708
    };

    typedef struct packed {
        logic [FW-1:0]    query;
        logic [IDX_W-1:0] semitone;
        logic [PC_W-1:0]  pitch_class;
        logic [OCT_W-1:0] octave;
        logic [FW-1:0]    note_freq;
    } t_note;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [A4_W-1:0]   i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [S_W-1:0]    s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [M_W-1:0]    m_axis_tdata;

    logic [FW-1:0]     pitch_table [NOTES];
    logic [FW-1:0]     freq_queue [$];
    t_note             expected_notes [$];

    logic              quiet     = 1'b0;
    logic              hold_req  = 1'b0;
    logic              hold_done = 1'b0;
    int                send_gap  = 0;
    int                stall_left = 0;
    int                hold_left = 0;
    int                idle_cycles = 0;
    int                result_count = 0;
    int                fail_count = 0;

    nearest_note_quantizer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // freq
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)     // semitone_index, pitch_class, octave, note_freq
    );

    always #5 i_clk = ~i_clk;

    // Note n = A4 * ratio(n mod 12) shifted by 34 - octave, rounded half up.
    function automatic void rebuild_pitch_table(input logic [A4_W-1:0] a4);
        logic [63:0] prod;
        int          shift;
        for (int n = 0; n < NOTES; n++) begin
            shift = 34 - n / 12;
            prod  = 64'(a4) * 64'(SEMITONE_RATIOS[(n % 12) * 31 +: 31]);
            prod  = (prod + (64'd1 << (shift - 1))) >> shift;
            pitch_table[n] = (prod > FREQ_MAX) ? FW'(FREQ_MAX) : prod[FW-1:0];
        end
    endfunction

    function automatic t_note nearest_note(input logic [FW-1:0] f);
        t_note r;
        int    lo;
        int    hi;
        int    mid;
        int    k;
        if (f < pitch_table[0]) begin
            k = 0;
        end else if (f > pitch_table[NOTES-1]) begin
            k = NOTES - 1;
        end else begin
            lo = 0;
            hi = NOTES - 1;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (pitch_table[mid] >= f) hi = mid;
                else lo = mid + 1;
            end
            k = lo;
            // Strictly below the midpoint picks the lower neighbor.
            if (k > 0 && 2 * 64'(f) < 64'(pitch_table[k-1]) + 64'(pitch_table[k]))
                k = k - 1;
        end
        r.query       = f;
        r.semitone    = IDX_W'(k);
        r.pitch_class = PC_W'(k % 12);
        r.octave      = OCT_W'(k / 12);
        r.note_freq   = pitch_table[k];
        return r;
    endfunction

    function automatic logic [FW-1:0] random_query();
        logic [63:0] lo_f;
        logic [63:0] hi_f;
        logic [63:0] v;
        int          k;
        k    = $urandom_range(NOTES - 2, 0);
        lo_f = 64'(pitch_table[k]);
        hi_f = 64'(pitch_table[k+1]);
        case ($urandom_range(9, 0))
            0, 1, 2: v = 64'($urandom_range(32'(hi_f), 32'(lo_f)));
            3, 4, 5: begin
                // Close around the decision point between two neighbors.
                v = ((lo_f + hi_f) >> 1) + 64'($urandom_range(4, 0));
                v = (v >= 2) ? v - 2 : v;
            end
            6:       v = 64'(pitch_table[$urandom_range(NOTES - 1, 0)]);
            7:       v = 64'($urandom_range(32'(pitch_table[0]), 0));
            8:       v = 64'($urandom_range(32'(FREQ_MAX), 32'(pitch_table[NOTES-1])));
            default: v = {40'd0, 24'($urandom())};
        endcase
        return (v > FREQ_MAX) ? FW'(FREQ_MAX) : v[FW-1:0];
    endfunction

    task automatic queue_landmarks();
        logic [FW:0] pair_sum;
        int          k;
        freq_queue.push_back('0);
        freq_queue.push_back({FW{1'b1}});
        freq_queue.push_back(FW'(24'h555555));
        freq_queue.push_back(FW'(24'hAAAAAA));
        freq_queue.push_back(pitch_table[0] - 1'b1);
        freq_queue.push_back(pitch_table[0]);
        freq_queue.push_back(pitch_table[0] + 1'b1);
        freq_queue.push_back(pitch_table[NOTES-1] - 1'b1);
        freq_queue.push_back(pitch_table[NOTES-1]);
        freq_queue.push_back(pitch_table[NOTES-1] + 1'b1);
        for (int j = 0; j < 3; j++) begin
            k = (j == 0) ? 0 : (j == 1) ? 56 : NOTES - 2;
            pair_sum = {1'b0, pitch_table[k]} + {1'b0, pitch_table[k+1]};
            freq_queue.push_back(pair_sum[FW:1] - 1'b1);
            freq_queue.push_back(pair_sum[FW:1]);
            freq_queue.push_back(pair_sum[FW:1] + FW'(pair_sum[0]));
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (freq_queue.size() != 0 || s_axis_tvalid || expected_notes.size() != 0);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap != 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(7, 0) == 0) begin
                send_gap      <= $urandom_range(6, 0);
                s_axis_tvalid <= 1'b0;
            end else if (freq_queue.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= S_W'(freq_queue.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            hold_left     <= 0;
        end else if (hold_req && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(7, 0) == 0) begin
            stall_left    <= $urandom_range(6, 0);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Prediction on each accepted request, comparison on each accepted result.
    always @(posedge i_clk) begin
        t_note want;
        t_note got;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_notes.push_back(nearest_note(s_axis_tdata[FW-1:0]));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.query       = '0;
            got.semitone    = m_axis_tdata[IDX_W-1:0];
            got.pitch_class = m_axis_tdata[IDX_W +: PC_W];
            got.octave      = m_axis_tdata[IDX_W+PC_W +: OCT_W];
            got.note_freq   = m_axis_tdata[IDX_W+PC_W+OCT_W +: FW];
            if (expected_notes.size() == 0) begin
                fail_count <= fail_count + 1;
                if (fail_count < 10)
                    $display("unexpected result %0d: note %0d freq %0d", result_count,
                             got.semitone, got.note_freq);
            end else begin
                want = expected_notes.pop_front();
                if (got.semitone != want.semitone || got.pitch_class != want.pitch_class ||
                    got.octave != want.octave || got.note_freq != want.note_freq) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display(
                            "mismatch %0d, query %0d: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                            result_count, want.query,
                            want.semitone, want.pitch_class, want.octave, want.note_freq,
                            got.semitone, got.pitch_class, got.octave, got.note_freq);
                end
            end
            result_count <= result_count + 1;
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** nearest_note_quantizer: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [A4_W-1:0] a4;
        rebuild_pitch_table(nnq_pkg::A4_RESET);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1:       a4 = 19'd409600;
                    2:       a4 = 19'd491520;
                    3:       a4 = '0;
                    4:       a4 = 19'd1;
                    5:       a4 = {A4_W{1'b1}};
                    6:       a4 = A4_W'($urandom_range(491520, 409600));
                    7:       a4 = A4_W'($urandom());
                    default: a4 = nnq_pkg::A4_RESET;
                endcase
                hold_req = (ph == 1);
                quiet    = (ph == PHASES - 1);
                @(posedge i_clk);
                i_cfg_we    <= 1'b1;
                i_cfg_wdata <= a4;
                @(posedge i_clk);
                i_cfg_we    <= 1'b0;
                rebuild_pitch_table(a4);
                @(negedge i_clk);
            end
            queue_landmarks();
            for (int n = 0; n < RANDOM_PER_PH; n++)
                freq_queue.push_back(random_query());
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_notes.size() == 0)
            $display("** nearest_note_quantizer: PASSED **");
        else
            $display("** nearest_note_quantizer: FAILED **");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/nnq_pkg.sv
hw/rtl/nnq_ram.sv
hw/rtl/nnq_ctrl.sv
hw/rtl/nnq_datapath.sv
hw/rtl/nearest_note_quantizer.sv
sim/nearest_note_quantizer_tb.sv
